@@ hdl/krs_pkg.sv @@
// Shared types and codes for the keyed record store.
// Used by krs_front, krs_engine and keyed_record_store_compacting. No dependencies.
`default_nettype none

package krs_pkg;

    // default sizes, overridden through top-level parameters
    localparam int MEM_BYTES_DEF  = 4096;
    localparam int HEAD_BYTES_DEF = 40;
    localparam int REC_HDR_DEF    = 32;

    // bytes in the key / length / size block of a record
    localparam int FIELD_BYTES = 12;
    // width of a computed record size (length is 12 bits, header at most 64)
    localparam int PSZ_W       = 13;
    localparam int LEN_W       = 12;
    localparam int REG_W       = 13;

    // commands
    localparam logic [2:0] CMD_HAS       = 3'd0;
    localparam logic [2:0] CMD_READ      = 3'd1;
    localparam logic [2:0] CMD_PUT_BEGIN = 3'd2;
    localparam logic [2:0] CMD_PUT_BYTE  = 3'd3;
    localparam logic [2:0] CMD_REMOVE    = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NO_KEY   = 2'd2;
    localparam logic [1:0] ST_NO_PUT   = 2'd3;

    // configuration register addresses
    localparam logic [2:0] ADDR_REGION = 3'd0;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] key;
        logic [11:0] offset;
        logic [11:0] length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [11:0] value_length;
        logic [7:0]  read_byte;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/keyed_record_store_compacting.sv @@
// Keyed record store with compaction: input queue, record engine and APB
// region register. Depends on krs_pkg, krs_front and krs_engine.
//
// Usage: commands enter on the s_axis channel (cmd in tuser, the other
// fields in tdata); each gives exactly one result beat on m_axis (status
// in tuser). The APB port holds one register, region_bytes at address 0,
// saturated to HEAD_BYTES+1 .. MEM_BYTES; writing it empties the store
// and is allowed only while the block is idle.
// Flow: a two-beat queue takes items while the engine works. Put byte and
// unknown commands pass only through dispatch. A lookup reads the 12 header
// bytes of each record walked through the memory's single read port, a read
// adds a capture state, a remove moves each byte behind the record down with
// a read and a write state, and a put begin runs a space check, then writes
// every byte of the new record with its header fields or zero fill.
// The result register holds while m_axis_tready is low; the engine takes no
// new item until its result slot is free, and the queue then fills.
// Reset empties the store and region_bytes returns to MEM_BYTES; memory
// contents are not cleared, no clearing pass is needed.
`default_nettype none

module keyed_record_store_compacting
    import krs_pkg::*;
#(
    parameter int MEM_BYTES           = MEM_BYTES_DEF,
    parameter int HEAD_BYTES          = HEAD_BYTES_DEF,
    parameter int RECORD_HEADER_BYTES = REC_HDR_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,   // key, offset, length, data_byte
    input  wire logic [2:0]   s_axis_tuser,   // cmd
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // found, value_length, read_byte, zero fill
    output logic [1:0]        m_axis_tuser,   // status
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int OW = $clog2(MEM_BYTES) + 1;
    localparam int CW = OW > REG_W ? OW : REG_W;

    item_t          s_item, q_item;
    logic           q_valid, q_ready;
    res_t           r;
    logic           cfg_wr;
    logic [OW-1:0]  region_reg, region_next;
    logic [CW-1:0]  wval;

    assign s_item = '{cmd:       s_axis_tuser,
                      key:       s_axis_tdata[63:0],
                      offset:    s_axis_tdata[75:64],
                      length:    s_axis_tdata[87:76],
                      data_byte: s_axis_tdata[95:88]};

    // apb register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_REGION);
    assign prdata = (paddr == ADDR_REGION) ? 32'(region_reg) : 32'd0;

    // region saturation
    always_comb
    begin
        wval = CW'(pwdata[REG_W-1:0]);
        priority if (wval < CW'(HEAD_BYTES + 1))
        begin
            region_next = OW'(HEAD_BYTES + 1);
        end
        else if (wval > CW'(MEM_BYTES))
        begin
            region_next = OW'(MEM_BYTES);
        end
        else
        begin
            region_next = OW'(wval);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= OW'(MEM_BYTES);
        end
        else if (cfg_wr)
        begin
            region_reg <= region_next;
        end
    end

    krs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (s_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    krs_engine #(
        .MEM_BYTES           (MEM_BYTES),
        .HEAD_BYTES          (HEAD_BYTES),
        .RECORD_HEADER_BYTES (RECORD_HEADER_BYTES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .clr        (cfg_wr),
        .region     (region_next),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (r)
    );

    // result beat
    assign m_axis_tdata = {3'd0, r.read_byte, r.value_length, r.found};
    assign m_axis_tuser = r.status;

endmodule

`default_nettype wire

@@ hdl/krs_front.sv @@
// Front end of the record store: a two-entry queue of accepted items.
// Depends on krs_pkg.
`default_nettype none

module krs_front
    import krs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output item_t      out_item
);

    item_t      buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = buf_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/krs_engine.sv @@
// Back end of the record store: record memory and the byte-serial sequencer
// that walks, reads, compacts and appends records. Depends on krs_pkg.
`default_nettype none

module krs_engine
    import krs_pkg::*;
#(
    parameter int MEM_BYTES           = MEM_BYTES_DEF,
    parameter int HEAD_BYTES          = HEAD_BYTES_DEF,
    parameter int RECORD_HEADER_BYTES = REC_HDR_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         clr,
    input  wire logic [$clog2(MEM_BYTES):0]   region,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire item_t                        item,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output res_t                              res
);

    localparam int AW      = $clog2(MEM_BYTES);
    localparam int OW      = AW + 1;
    localparam int PW      = (OW > 16 ? OW : 16) + 1;
    localparam int HDR_EFF = RECORD_HEADER_BYTES < FIELD_BYTES ? FIELD_BYTES
                                                               : RECORD_HEADER_BYTES;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DISP  = 11'b000_0000_0010,
        S_WCHK  = 11'b000_0000_0100,
        S_WRD   = 11'b000_0000_1000,
        S_WEVAL = 11'b000_0001_0000,
        S_RDCAP = 11'b000_0010_0000,
        S_SHRD  = 11'b000_0100_0000,
        S_SHWR  = 11'b000_1000_0000,
        S_PCHK  = 11'b001_0000_0000,
        S_FILL  = 11'b010_0000_0000,
        S_SPARE = 11'b100_0000_0000
    } state_t;

    // byte of a freshly appended record
    function automatic logic [7:0] fill_byte(input logic [PSZ_W-1:0] idx,
                                             input logic [63:0] k,
                                             input logic [11:0] len,
                                             input logic [PSZ_W-1:0] sz);
        logic [15:0] sz16;
        logic [7:0]  b;
        sz16 = 16'(sz);
        b    = 8'd0;
        if (idx < PSZ_W'(8))
        begin
            b = k[8*idx[2:0] +: 8];
        end
        else if (idx == PSZ_W'(8))
        begin
            b = len[7:0];
        end
        else if (idx == PSZ_W'(9))
        begin
            b = {4'd0, len[11:8]};
        end
        else if (idx == PSZ_W'(10))
        begin
            b = sz16[7:0];
        end
        else if (idx == PSZ_W'(11))
        begin
            b = sz16[15:8];
        end
        return b;
    endfunction

    logic [7:0] mem [MEM_BYTES];

    state_t           state_reg, state_next;
    item_t            item_reg, item_next;
    res_t             res_reg, res_next;
    logic             rv_reg, rv_next;
    logic [OW-1:0]    end_reg, end_next;
    logic [OW-1:0]    free_reg, free_next;
    logic             open_reg, open_next;
    logic [OW-1:0]    ppos_reg, ppos_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [PW-1:0]    wpos_reg, wpos_next;
    logic [3:0]       hidx_reg, hidx_next;
    logic [7:0]       hdr_reg [FIELD_BYTES];
    logic [7:0]       hdr_next [FIELD_BYTES];
    logic [OW-1:0]    src_reg, src_next;
    logic [OW-1:0]    dst_reg, dst_next;
    logic [OW-1:0]    cnt_reg, cnt_next;
    logic [OW-1:0]    rsz_reg, rsz_next;
    logic [PSZ_W-1:0] psz_reg, psz_next;
    logic [PSZ_W-1:0] fidx_reg, fidx_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [7:0]       mem_wdata, rdata_reg;

    logic [63:0]      hkey;
    logic [15:0]      hlen, hsize;
    logic [PW-1:0]    span, size_w;
    logic [PSZ_W-1:0] ptmp;
    logic             slot_free;

    assign slot_free  = !rv_reg || res_ready;
    assign item_ready = (state_reg == S_IDLE) && slot_free;
    assign res_valid  = rv_reg;
    assign res        = res_reg;

    // record memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // header fields of the record under the walk
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            hkey[8*i +: 8] = hdr_reg[i];
        end
        hlen   = {hdr_reg[9], hdr_reg[8]};
        hsize  = {hdr_reg[11], hdr_reg[10]};
        span   = PW'(end_reg) - wpos_reg;
        size_w = (PW'(hsize) > span) ? span : PW'(hsize);
        ptmp   = PSZ_W'(item_reg.length) + PSZ_W'(HDR_EFF - 1);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        rv_next    = rv_reg;
        end_next   = end_reg;
        free_next  = free_reg;
        open_next  = open_reg;
        ppos_next  = ppos_reg;
        left_next  = left_reg;
        wpos_next  = wpos_reg;
        hidx_next  = hidx_reg;
        hdr_next   = hdr_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        cnt_next   = cnt_reg;
        rsz_next   = rsz_reg;
        psz_next   = psz_reg;
        fidx_next  = fidx_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = '0;

        if (rv_reg && res_ready)
        begin
            rv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && slot_free)
                begin
                    item_next  = item;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                res_next = '0;
                if (item_reg.cmd != CMD_PUT_BYTE && item_reg.cmd <= CMD_REMOVE)
                begin
                    open_next = 1'b0;
                end
                psz_next  = {ptmp[PSZ_W-1:2], 2'b00} + PSZ_W'(4);
                wpos_next = PW'(HEAD_BYTES);
                priority if (item_reg.cmd == CMD_PUT_BYTE)
                begin
                    if (!open_reg)
                    begin
                        res_next.status = ST_NO_PUT;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = ppos_reg[AW-1:0];
                        mem_wdata = item_reg.data_byte;
                        ppos_next = ppos_reg + OW'(1);
                        left_next = left_reg - LEN_W'(1);
                        open_next = (left_reg != LEN_W'(1));
                    end
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else if (item_reg.cmd <= CMD_REMOVE)
                begin
                    state_next = S_WCHK;
                end
                else
                begin
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WCHK:
            begin
                if (wpos_reg >= PW'(end_reg))
                begin
                    if (item_reg.cmd == CMD_PUT_BEGIN)
                    begin
                        state_next = S_PCHK;
                    end
                    else
                    begin
                        res_next.status = ST_NO_KEY;
                        rv_next         = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    hidx_next  = 4'd0;
                    state_next = S_WRD;
                end
            end
            S_WRD:
            begin
                // reads issue one byte ahead of the capture
                mem_raddr = AW'(wpos_reg + PW'(hidx_reg));
                if (hidx_reg != 4'd0)
                begin
                    hdr_next[hidx_reg - 4'd1] = rdata_reg;
                end
                hidx_next = hidx_reg + 4'd1;
                if (hidx_reg == 4'(FIELD_BYTES))
                begin
                    state_next = S_WEVAL;
                end
            end
            S_WEVAL:
            begin
                if (hkey == item_reg.key)
                begin
                    res_next.found        = 1'b1;
                    res_next.value_length = hlen[11:0];
                    rsz_next = OW'(size_w);
                    src_next = OW'(wpos_reg + size_w);
                    dst_next = OW'(wpos_reg);
                    cnt_next = OW'(span - size_w);
                    priority if (item_reg.cmd == CMD_HAS)
                    begin
                        rv_next    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (item_reg.cmd == CMD_READ)
                    begin
                        if (item_reg.offset < hlen[11:0])
                        begin
                            mem_raddr  = AW'(wpos_reg + PW'(FIELD_BYTES)
                                             + PW'(item_reg.offset));
                            state_next = S_RDCAP;
                        end
                        else
                        begin
                            rv_next    = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = S_SHRD;
                    end
                end
                else if (hsize == 16'd0)
                begin
                    if (item_reg.cmd == CMD_PUT_BEGIN)
                    begin
                        state_next = S_PCHK;
                    end
                    else
                    begin
                        res_next.status = ST_NO_KEY;
                        rv_next         = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    wpos_next  = wpos_reg + PW'(hsize);
                    state_next = S_WCHK;
                end
            end
            S_RDCAP:
            begin
                res_next.read_byte = rdata_reg;
                rv_next            = 1'b1;
                state_next         = S_IDLE;
            end
            S_SHRD:
            begin
                // compaction: each byte is read here and written down in S_SHWR
                if (cnt_reg == '0)
                begin
                    end_next  = end_reg - rsz_reg;
                    free_next = free_reg + rsz_reg;
                    if (item_reg.cmd == CMD_PUT_BEGIN)
                    begin
                        state_next = S_PCHK;
                    end
                    else
                    begin
                        rv_next    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    mem_raddr  = src_reg[AW-1:0];
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = dst_reg[AW-1:0];
                mem_wdata  = rdata_reg;
                src_next   = src_reg + OW'(1);
                dst_next   = dst_reg + OW'(1);
                cnt_next   = cnt_reg - OW'(1);
                state_next = S_SHRD;
            end
            S_PCHK:
            begin
                if (PW'(free_reg) < PW'(psz_reg)
                    || PW'(end_reg) + PW'(psz_reg) > PW'(MEM_BYTES))
                begin
                    res_next.status       = ST_NO_SPACE;
                    res_next.found        = 1'b0;
                    res_next.value_length = '0;
                    rv_next               = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    fidx_next  = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(PW'(end_reg) + PW'(fidx_reg));
                mem_wdata = fill_byte(fidx_reg, item_reg.key, item_reg.length, psz_reg);
                fidx_next = fidx_reg + PSZ_W'(1);
                if (fidx_reg == psz_reg - PSZ_W'(1))
                begin
                    end_next              = end_reg + OW'(psz_reg);
                    free_next             = free_reg - OW'(psz_reg);
                    ppos_next             = end_reg + OW'(FIELD_BYTES);
                    left_next             = item_reg.length;
                    open_next             = (item_reg.length != '0);
                    res_next.status       = ST_OK;
                    res_next.found        = 1'b1;
                    res_next.value_length = item_reg.length;
                    rv_next               = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        hdr_reg  <= hdr_next;
        wpos_reg <= wpos_next;
        hidx_reg <= hidx_next;
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        cnt_reg  <= cnt_next;
        rsz_reg  <= rsz_next;
        psz_reg  <= psz_next;
        fidx_reg <= fidx_next;
    end

    // control state; a region write empties the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
            end_reg   <= OW'(HEAD_BYTES);
            free_reg  <= OW'(MEM_BYTES - HEAD_BYTES);
            open_reg  <= 1'b0;
            ppos_reg  <= '0;
            left_reg  <= '0;
        end
        else if (clr)
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            end_reg   <= OW'(HEAD_BYTES);
            free_reg  <= region - OW'(HEAD_BYTES);
            open_reg  <= 1'b0;
            ppos_reg  <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            end_reg   <= end_next;
            free_reg  <= free_next;
            open_reg  <= open_next;
            ppos_reg  <= ppos_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/krs_checker.sv @@
// Scoreboard for the keyed record store: watches the stream and APB ports,
// predicts every result beat and compares it. Depends on krs_pkg.
`default_nettype none

module krs_checker
    import krs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [95:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = 4096;
    localparam int HEAD        = 40;
    localparam int REC_HDR     = 32;
    localparam int HDR_EFF     = (REC_HDR < FIELD_BYTES) ? FIELD_BYTES : REC_HDR;
    localparam int unsigned NO_REC = 32'hFFFF_FFFF;

    // shadow of the store
    logic [7:0]  store_mem [0:STORE_BYTES-1];
    int unsigned region_sz;
    int unsigned used_end;
    int unsigned free_cnt;
    int unsigned wr_pos;
    int unsigned bytes_left;
    bit          put_active;

    res_t expected_q[$];
    int   fails;

    function automatic logic [63:0] get_le(int unsigned a, int n);
        logic [63:0] v;
        v = '0;
        for (int i = n - 1; i >= 0; i--)
            v = (v << 8) | 64'(store_mem[(a + i) % STORE_BYTES]);
        return v;
    endfunction

    function automatic void put_le(int unsigned a, logic [63:0] v, int n);
        for (int i = 0; i < n; i++)
            store_mem[(a + i) % STORE_BYTES] = v[8*i +: 8];
    endfunction

    // walk the record chain for a key
    function automatic int unsigned locate(logic [63:0] k);
        int unsigned pos;
        int unsigned sz;
        pos = HEAD;
        while (pos < used_end) begin
            if (get_le(pos, 8) == k)
                return pos;
            sz = 32'(get_le(pos + 10, 2));
            if (sz == 0)
                return NO_REC;
            pos += sz;
        end
        return NO_REC;
    endfunction

    // compact the store over one record
    function automatic void drop_record(int unsigned pos);
        int unsigned sz;
        int unsigned n;
        sz = 32'(get_le(pos + 10, 2));
        if (pos >= used_end || used_end > STORE_BYTES)
            return;
        if (sz > used_end - pos)
            sz = used_end - pos;
        n = used_end - pos - sz;
        for (int unsigned i = 0; i < n; i++)
            store_mem[(pos + i) % STORE_BYTES] = store_mem[(pos + sz + i) % STORE_BYTES];
        free_cnt += sz;
        used_end -= sz;
    endfunction

    function automatic void empty_store();
        used_end   = HEAD;
        free_cnt   = region_sz - HEAD;
        put_active = 0;
        wr_pos     = 0;
        bytes_left = 0;
    endfunction

    function automatic res_t predict_result(item_t it);
        res_t        r;
        int unsigned pos;
        int unsigned sz;
        r = '0;
        if (it.cmd != CMD_PUT_BYTE && it.cmd <= CMD_REMOVE)
            put_active = 0;
        if (it.cmd == CMD_HAS || it.cmd == CMD_READ || it.cmd == CMD_REMOVE) begin
            pos = locate(it.key);
            if (pos == NO_REC)
                r.status = ST_NO_KEY;
            else
            begin
                r.found        = 1'b1;
                r.value_length = 12'(get_le(pos + 8, 2));
                if (it.cmd == CMD_READ && it.offset < r.value_length)
                    r.read_byte = store_mem[(pos + FIELD_BYTES + it.offset) % STORE_BYTES];
                if (it.cmd == CMD_REMOVE)
                    drop_record(pos);
            end
        end
        else if (it.cmd == CMD_PUT_BEGIN) begin
            sz  = ((it.length + HDR_EFF - 1) / 4) * 4 + 4;
            pos = locate(it.key);
            if (pos != NO_REC)
                drop_record(pos);
            if (free_cnt < sz || used_end + sz > STORE_BYTES)
                r.status = ST_NO_SPACE;
            else
            begin
                for (int unsigned i = 0; i < sz; i++)
                    store_mem[(used_end + i) % STORE_BYTES] = 8'h00;
                put_le(used_end, it.key, 8);
                put_le(used_end + 8, 64'(it.length), 2);
                put_le(used_end + 10, 64'(sz), 2);
                wr_pos      = used_end + FIELD_BYTES;
                used_end   += sz;
                free_cnt   -= sz;
                bytes_left  = it.length;
                put_active  = (it.length > 0);
                r.found        = 1'b1;
                r.value_length = it.length;
            end
        end
        else if (it.cmd == CMD_PUT_BYTE) begin
            if (!put_active)
                r.status = ST_NO_PUT;
            else
            begin
                store_mem[wr_pos % STORE_BYTES] = it.data_byte;
                wr_pos = (wr_pos + 1) & 32'h1FFF;
                bytes_left--;
                if (bytes_left == 0)
                    put_active = 0;
            end
        end
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    initial
    begin
        foreach (store_mem[i])
            store_mem[i] = 8'h00;
        region_sz = STORE_BYTES;
        empty_store();
        fails   = 0;
    end

    // sample beats at each edge: config, input, then result
    always @(posedge clk)
    begin
        item_t it;
        res_t  got;
        res_t  want;
        int unsigned r;
        if (rst_n) begin
            if (psel && penable && pwrite && pready && paddr == ADDR_REGION) begin
                r = pwdata & 32'h1FFF;
                if (r < HEAD + 1)
                    r = HEAD + 1;
                if (r > STORE_BYTES)
                    r = STORE_BYTES;
                region_sz = r;
                empty_store();
            end
            if (s_tvalid && s_tready) begin
                it.cmd       = s_tuser;
                it.key       = s_tdata[63:0];
                it.offset    = s_tdata[75:64];
                it.length    = s_tdata[87:76];
                it.data_byte = s_tdata[95:88];
                expected_q.push_back(predict_result(it));
            end
            if (m_tvalid && m_tready) begin
                got.status       = m_tuser;
                got.found        = m_tdata[0];
                got.value_length = m_tdata[12:1];
                got.read_byte    = m_tdata[20:13];
                if (expected_q.size() == 0) begin
                    $display("unexpected result beat at %0t", $realtime);
                    fails++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.status != want.status)
                        report("status", got.status, want.status);
                    if (got.found != want.found)
                        report("found", got.found, want.found);
                    if (got.value_length != want.value_length)
                        report("value_length", got.value_length, want.value_length);
                    if (got.read_byte != want.read_byte)
                        report("read_byte", got.read_byte, want.read_byte);
                end
            end
        end
        errors  <= fails;
        pending <= expected_q.size();
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Stimulus and verdict for keyed_record_store_compacting: directed and random
// command streams over several region sizes. Depends on krs_pkg and krs_checker.
`default_nettype none

module tb_top
    import krs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT     = 60000000;
    localparam int KEY_COUNT = 10;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // key, offset, length, data_byte
    logic [2:0]  s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // found, value_length, read_byte, zero fill
    logic [1:0]  m_axis_tuser;   // status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int cycles;
    int send_idle;
    int recv_idle;
    logic hold_req;
    int items_sent;
    int settings_done;
    logic [63:0] key_pool [KEY_COUNT];

    keyed_record_store_compacting dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    krs_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls plus long hold-offs on request
    initial
    begin
        int hold_cnt;
        hold_cnt = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
                hold_cnt = 400;
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // one input beat, with random gaps ahead of it
    task automatic send_item(logic [2:0] cmd, logic [63:0] key, logic [11:0] off,
                             logic [11:0] len, logic [7:0] dbyte);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {dbyte, len, off, key};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic apb_write(logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_REGION;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        settings_done++;
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // put sequences with random content, some cut short, plus lookups and noise
    task automatic random_phase(int count);
        int stop_at;
        int sel;
        int len;
        int nbytes;
        logic [63:0] k;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            sel = $urandom_range(99);
            k = ($urandom_range(9) == 0) ? rand_key() : key_pool[$urandom_range(KEY_COUNT-1)];
            if (sel < 40) begin
                if ($urandom_range(40) == 0)
                    len = $urandom_range(4095);
                else
                    len = $urandom_range(40);
                nbytes = (len > 48) ? $urandom_range(8) : len;
                if ($urandom_range(7) == 0 && nbytes > 0)
                    nbytes = $urandom_range(nbytes - 1);
                send_item(CMD_PUT_BEGIN, k, 12'($urandom), 12'(len), 8'($urandom));
                for (int i = 0; i < nbytes; i++)
                    send_item(CMD_PUT_BYTE, rand_key(), 12'($urandom), 12'($urandom),
                              8'($urandom));
            end
            else if (sel < 60)
                send_item(CMD_READ, k, ($urandom_range(3) == 0) ? 12'($urandom)
                          : 12'($urandom_range(44)), 12'($urandom), 8'($urandom));
            else if (sel < 75)
                send_item(CMD_HAS, k, 12'($urandom), 12'($urandom), 8'($urandom));
            else if (sel < 90)
                send_item(CMD_REMOVE, k, 12'($urandom), 12'($urandom), 8'($urandom));
            else if (sel < 95)
                send_item(CMD_PUT_BYTE, rand_key(), 12'($urandom), 12'($urandom),
                          8'($urandom));
            else
                send_item(3'($urandom_range(7, 5)), rand_key(), 12'($urandom),
                          12'($urandom), 8'($urandom));
        end
    endtask

    task automatic set_idling(int snd, int rcv);
        send_idle = snd;
        recv_idle <= rcv;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_HAS;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = ADDR_REGION;
        pwdata        = '0;
        hold_req      = 1'b0;
        send_idle     = 10;
        recv_idle     = 78;
        items_sent    = 0;
        settings_done = 0;
        for (int i = 0; i < KEY_COUNT; i++)
            key_pool[i] = rand_key();
        key_pool[0] = 64'h7FFF_FFFF_FFFF_FFFF;
        key_pool[1] = 64'h8000_0000_0000_0000;
        key_pool[2] = 64'hFFFF_FFFF_FFFF_FFFF;
        key_pool[3] = 64'h0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and corner cases at the reset region size
        send_item(CMD_PUT_BYTE, 64'h0, 12'h0, 12'h0, 8'hFF);        // no open put
        send_item(CMD_HAS, key_pool[0], 12'h0, 12'h0, 8'h00);       // missing key
        send_item(CMD_PUT_BEGIN, key_pool[0], 12'h0, 12'h0, 8'h0);  // zero length
        send_item(CMD_PUT_BYTE, 64'h0, 12'h0, 12'h0, 8'h11);        // nothing open
        send_item(CMD_PUT_BEGIN, key_pool[1], 12'hFFF, 12'd3, 8'h0);
        send_item(CMD_PUT_BYTE, 64'hFFFF_FFFF_FFFF_FFFF, 12'hFFF, 12'hFFF, 8'hFF);
        send_item(CMD_PUT_BYTE, 64'h0, 12'h0, 12'h0, 8'h00);
        send_item(CMD_PUT_BYTE, 64'h0, 12'h0, 12'h0, 8'hA5);
        send_item(CMD_READ, key_pool[1], 12'd0, 12'h0, 8'h0);
        send_item(CMD_READ, key_pool[1], 12'd2, 12'h0, 8'h0);
        send_item(CMD_READ, key_pool[1], 12'd3, 12'h0, 8'h0);       // past length
        send_item(CMD_READ, key_pool[1], 12'hFFF, 12'h0, 8'h0);
        send_item(CMD_PUT_BEGIN, key_pool[2], 12'h0, 12'd5, 8'h0);  // interrupted put
        send_item(CMD_PUT_BYTE, 64'h0, 12'h0, 12'h0, 8'h5A);
        send_item(CMD_HAS, key_pool[2], 12'h0, 12'h0, 8'h0);
        send_item(CMD_PUT_BYTE, 64'h0, 12'h0, 12'h0, 8'h77);
        send_item(CMD_READ, key_pool[2], 12'd1, 12'h0, 8'h0);
        send_item(CMD_PUT_BEGIN, key_pool[1], 12'h0, 12'd1, 8'h0);  // replace
        send_item(CMD_REMOVE, key_pool[0], 12'h0, 12'h0, 8'h0);
        send_item(CMD_REMOVE, key_pool[0], 12'h0, 12'h0, 8'h0);     // already gone
        send_item(3'd5, 64'h0, 12'h0, 12'h0, 8'h0);
        send_item(3'd6, 64'h0, 12'h0, 12'h0, 8'h0);
        send_item(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 12'hFFF, 12'hFFF, 8'hFF);
        send_item(CMD_PUT_BEGIN, key_pool[2], 12'h0, 12'hFFF, 8'h0); // no space, old removed
        send_item(CMD_HAS, key_pool[2], 12'h0, 12'h0, 8'h0);
        drain();

        // smallest region: every put fails for lack of space
        apb_write(32'h0);
        send_item(CMD_PUT_BEGIN, key_pool[3], 12'h0, 12'h0, 8'h0);
        send_item(CMD_HAS, key_pool[1], 12'h0, 12'h0, 8'h0);
        drain();

        // full region through saturation, sender idles lightly
        apb_write(32'hFFFF_FFFF);
        set_idling(10, 78);
        random_phase(190);
        hold_req <= 1'b1;                  // long receiver hold-off
        @(posedge clk);
        hold_req <= 1'b0;
        random_phase(50);
        drain();

        // random mid-size region, receiver idles lightly
        apb_write({19'($urandom_range(32'h7FFFF)), 13'($urandom_range(4096, 300))});
        set_idling(78, 10);
        random_phase(170);
        drain();                           // sender pause until all results arrive
        random_phase(150);
        drain();

        // tight region, then the largest, without idling
        apb_write(32'd200);
        set_idling(0, 0);
        random_phase(180);
        drain();
        apb_write(32'd4096);
        random_phase(180);
        drain();
        repeat (50) @(posedge clk);

        $display("sent %0d items over %0d region settings; puts, reads, lookups,",
                 items_sent, settings_done);
        $display("removes, stray bytes and unknown commands under stalls and hold-offs");
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
